### rtl/core/rpot_pkg.sv
`timescale 1ns / 1ps

package rpot_pkg;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_LIST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_LIST,
    ST_NONE
  } state_e;

  localparam logic [1:0] SORT_SIMPLE = 2'd0;

  typedef struct packed {
    op_e         op;
    logic [31:0] order_key;
    logic [1:0]  sort_kind;
    logic        group_sel;
    logic [4:0]  function_set;
    logic [4:0]  start_slot;
    logic [31:0] pass_mask;
  } rpot_in_t;

  typedef struct packed {
    logic [4:0]  slot_id;
    logic        found;
    logic [1:0]  slot_sort_kind;
    logic        slot_group;
    logic [4:0]  slot_function_set;
    logic [31:0] group_bits;
    logic [31:0] simple_sort_bits;
    logic        last;
  } rpot_out_t;

  // One position of the key-ordered list.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [4:0]  slot;
    logic [1:0]  mode;
    logic        grp;
    logic [4:0]  fset;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   insert;
    logic   rotate;
    entry_t ent;
  } cell_cmd_t;

  // Left neighbor seen by the head cell: occupied, never greater.
  localparam entry_t ENTRY_OPEN = '{valid: 1'b1, default: '0};

endpackage

### rtl/core/render_pass_ordered_table_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Beat
// in      | input     | in_valid_i / in_stall_o   | rpot_in_t  (add or list request)
// out     | output    | out_valid_o / out_stall_i | rpot_out_t (one result)
//
// Add: accepted, then the pass is placed once out is free; intake stalls until then.
// List: accepted, then one entry per cycle while out is not stalled on a hit; the chain
//   rotates once around so cell 0 shows every entry in key order, then is back in place.
// No clearing pass: after rst_ni the table is empty at once.
// A stall on out holds the walk only when cell 0 holds a matching entry.

module render_pass_ordered_table_unit #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rpot_pkg::rpot_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rpot_pkg::rpot_out_t out_data_o
);
  import rpot_pkg::*;

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  // control state
  state_e                  state_q, state_d;
  logic [SLOT_COUNT-1:0]   active_q, active_d;
  logic [SLOT_COUNT-1:0]   gmask_q [2];
  logic [SLOT_COUNT-1:0]   gmask_d [2];
  logic [SLOT_COUNT-1:0]   simple_q, simple_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           steps_q, steps_d;
  logic [SLOT_COUNT-1:0]   rem_q, rem_d;
  logic                    out_valid_q, out_valid_d;

  // payload
  rpot_in_t                req_q, req_d;
  rpot_out_t               out_q, out_d;

  // chain
  cell_cmd_t               cmd;
  entry_t                  cell_ent [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   cell_gt;

  // free-slot search and list walk
  logic                    out_free;
  logic [SLOT_COUNT-1:0]   avail;
  logic                    free_ok;
  logic [SW-1:0]           free_idx;
  logic [SLOT_COUNT-1:0]   free_oh;
  logic [SLOT_COUNT-1:0]   gm_new;
  logic [SLOT_COUNT-1:0]   head_oh;
  logic                    hit;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_gt;

    if (g == 0) begin : g_head
      assign prev_ent = ENTRY_OPEN;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_ent = cell_ent[g-1];
      assign prev_gt  = cell_gt[g-1];
    end

    if (g == SLOT_COUNT - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = cell_ent[g+1];
    end

    rpot_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .prev_i    (prev_ent),
      .prev_gt_i (prev_gt),
      .next_i    (next_ent),
      .head_i    (cell_ent[0]),
      .ent_o     (cell_ent[g]),
      .gt_o      (cell_gt[g])
    );
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // lowest free slot at or above start_slot; shifts past the table leave nothing
  assign avail = ~active_q & ({SLOT_COUNT{1'b1}} << req_q.start_slot);
  assign free_ok = |avail;

  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (avail[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  assign free_oh = free_ok ? (SLOT_COUNT'(1) << free_idx) : '0;
  assign gm_new  = gmask_q[req_q.group_sel] | free_oh;

  assign head_oh = SLOT_COUNT'(1) << cell_ent[0].slot;
  assign hit     = |(rem_q & head_oh);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    gmask_d     = gmask_q;
    simple_d    = simple_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    rem_d       = rem_q;
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    cmd            = '0;
    cmd.ent.valid  = 1'b1;
    cmd.ent.key    = req_q.order_key;
    cmd.ent.slot   = 5'(free_idx);
    cmd.ent.mode   = req_q.sort_kind;
    cmd.ent.grp    = req_q.group_sel;
    cmd.ent.fset   = req_q.function_set;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if (in_data_i.op == OP_ADD) begin
            state_d = ST_ADD;
          end else begin
            rem_d   = in_data_i.pass_mask[SLOT_COUNT-1:0] & active_q;
            steps_d = cnt_q;
            state_d = (|rem_d) ? ST_LIST : ST_NONE;
          end
        end
      end

      ST_ADD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          if (free_ok) begin
            cmd.insert                = 1'b1;
            active_d                  = active_q | free_oh;
            gmask_d[req_q.group_sel]  = gm_new;
            if (req_q.sort_kind == SORT_SIMPLE) begin
              simple_d = simple_q | free_oh;
            end
            cnt_d                   = cnt_q + CW'(1);
            out_d.slot_id           = 5'(free_idx);
            out_d.found             = 1'b1;
            out_d.slot_sort_kind    = req_q.sort_kind;
            out_d.slot_group        = req_q.group_sel;
            out_d.slot_function_set = req_q.function_set;
          end
          out_d.group_bits       = 32'(gm_new);
          out_d.simple_sort_bits = 32'(simple_d);
          state_d                = ST_IDLE;
        end
      end

      ST_LIST: begin
        if (steps_q == '0) begin
          state_d = ST_IDLE;
        end else if (!hit || out_free) begin
          cmd.rotate = 1'b1;
          steps_d    = steps_q - CW'(1);
          if (hit) begin
            rem_d                   = rem_q & ~head_oh;
            out_valid_d             = 1'b1;
            out_d                   = '0;
            out_d.slot_id           = cell_ent[0].slot;
            out_d.found             = 1'b1;
            out_d.slot_sort_kind    = cell_ent[0].mode;
            out_d.slot_group        = cell_ent[0].grp;
            out_d.slot_function_set = cell_ent[0].fset;
            out_d.last              = ~|rem_d;
          end
        end
      end

      ST_NONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      gmask_q[0]  <= '0;
      gmask_q[1]  <= '0;
      simple_q    <= '0;
      cnt_q       <= '0;
      steps_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      gmask_q[0]  <= gmask_d[0];
      gmask_q[1]  <= gmask_d[1];
      simple_q    <= simple_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/rpot_cell.sv
`timescale 1ns / 1ps

module rpot_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpot_pkg::cell_cmd_t cmd_i,
  input  rpot_pkg::entry_t    prev_i,
  input  logic                prev_gt_i,
  input  rpot_pkg::entry_t    next_i,
  input  rpot_pkg::entry_t    head_i,
  output rpot_pkg::entry_t    ent_o,
  output logic                gt_o
);
  import rpot_pkg::*;

  logic   valid_q;
  entry_t data_q;
  entry_t ent;
  entry_t ent_d;
  logic   gt;

  always_comb begin
    ent       = data_q;
    ent.valid = valid_q;
  end

  // Stored key strictly greater than the incoming one: this entry moves right.
  assign gt = valid_q && (data_q.key > cmd_i.ent.key);

  always_comb begin
    ent_d = ent;
    if (cmd_i.insert) begin
      if (prev_gt_i) begin
        ent_d = prev_i;
      end else if ((gt || !valid_q) && prev_i.valid) begin
        ent_d = cmd_i.ent;
      end
    end else if (cmd_i.rotate && valid_q) begin
      // tail of the list wraps around to the head
      ent_d = next_i.valid ? next_i : head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= ent_d;
  end

  assign ent_o = ent;
  assign gt_o  = gt;

endmodule

### rtl/core/rpot_chk.sv
`timescale 1ns / 1ps

module rpot_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rpot_pkg::rpot_out_t out_data_o
);
  import rpot_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // one item at a time: intake closes right after a beat is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // a miss is always the only result of its item, with slot zero
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.last && (out_data_o.slot_id == 5'd0))
    else $error("miss result malformed");

  // only list walks give non-final results, and those carry no masks
  a_list_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
      (out_data_o.group_bits == 32'd0) && (out_data_o.simple_sort_bits == 32'd0))
    else $error("list result carries mask bits");

endmodule

bind render_pass_ordered_table_unit rpot_chk u_rpot_chk (.*);

### tb/render_pass_ordered_table_unit_test.sv
`timescale 1ns / 1ps

module render_pass_ordered_table_unit_test;
  import rpot_pkg::*;

  localparam int unsigned SLOTS        = 32;
  localparam int unsigned RANDOM_ITEMS = 310;
  // Worst case per item: 32 result beats, each behind a long receiver stall,
  // plus sender gaps; several times that over ~370 items still fits here.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Idle wait after the queue drains, to catch stray beats.
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  rpot_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  rpot_out_t out_data_o;

  render_pass_ordered_table_unit #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the pass table. Updated when an input beat is accepted, so
  // the reply queue always holds results in the order the block must emit them.
  // ---------------------------------------------------------------------------
  bit          slot_taken[SLOTS];
  logic [31:0] slot_key_m[SLOTS];
  logic [1:0]  slot_mode_m[SLOTS];
  logic        slot_grp_m[SLOTS];
  logic [4:0]  slot_fset_m[SLOTS];
  logic [4:0]  key_order[$];           // active slots, ascending key, ties by arrival
  logic [31:0] group_mask_m[2] = '{default: '0};
  logic [31:0] simple_mask_m   = '0;
  rpot_out_t   table_replies_q[$];     // result beats still owed by the block

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  function automatic void apply_table_item(input rpot_in_t item);
    rpot_out_t   reply;
    int unsigned slot;
    int unsigned pos;
    bit          any_hit;
    reply   = '0;
    any_hit = 1'b0;
    if (item.op == OP_ADD) begin
      // first free slot at or above the requested start
      slot = item.start_slot;
      while (slot < SLOTS && slot_taken[slot]) slot++;
      if (slot >= SLOTS || key_order.size() >= SLOTS) begin
        // no room: masks reported unchanged, nothing stored
        reply.group_bits       = group_mask_m[item.group_sel];
        reply.simple_sort_bits = simple_mask_m;
      end else begin
        slot_taken[slot]  = 1'b1;
        slot_key_m[slot]  = item.order_key;
        slot_mode_m[slot] = item.sort_kind;
        slot_grp_m[slot]  = item.group_sel;
        slot_fset_m[slot] = item.function_set;
        // stable insert: go past every entry whose key is not greater
        pos = 0;
        while (pos < key_order.size() && slot_key_m[key_order[pos]] <= item.order_key) pos++;
        key_order.insert(pos, 5'(slot));
        group_mask_m[item.group_sel][slot] = 1'b1;
        if (item.sort_kind == SORT_SIMPLE) simple_mask_m[slot] = 1'b1;
        reply.slot_id           = 5'(slot);
        reply.found             = 1'b1;
        reply.slot_sort_kind    = item.sort_kind;
        reply.slot_group        = item.group_sel;
        reply.slot_function_set = item.function_set;
        reply.group_bits        = group_mask_m[item.group_sel];
        reply.simple_sort_bits  = simple_mask_m;
      end
      reply.last = 1'b1;
      table_replies_q.push_back(reply);
    end else begin
      // walk in key order, one beat per selected active slot
      foreach (key_order[i]) begin
        if (item.pass_mask[key_order[i]]) begin
          reply                   = '0;
          reply.slot_id           = key_order[i];
          reply.found             = 1'b1;
          reply.slot_sort_kind    = slot_mode_m[key_order[i]];
          reply.slot_group        = slot_grp_m[key_order[i]];
          reply.slot_function_set = slot_fset_m[key_order[i]];
          table_replies_q.push_back(reply);
          any_hit = 1'b1;
        end
      end
      if (any_hit) begin
        table_replies_q[table_replies_q.size() - 1].last = 1'b1;
      end else begin
        reply      = '0;
        reply.last = 1'b1;
        table_replies_q.push_back(reply);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Fields the operation ignores are still randomized.
  // ---------------------------------------------------------------------------
  function automatic rpot_in_t random_fields();
    rpot_in_t item;
    item.op           = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_LIST;
    item.order_key    = $urandom;
    item.sort_kind    = 2'($urandom_range(0, 3));
    item.group_sel    = 1'($urandom_range(0, 1));
    item.function_set = 5'($urandom_range(0, 31));
    item.start_slot   = 5'($urandom_range(0, 31));
    item.pass_mask    = $urandom;
    return item;
  endfunction

  function automatic rpot_in_t add_item(input logic [31:0] key, input logic [1:0] mode,
                                        input logic grp, input logic [4:0] fset,
                                        input logic [4:0] start);
    rpot_in_t item;
    item              = random_fields();
    item.op           = OP_ADD;
    item.order_key    = key;
    item.sort_kind    = mode;
    item.group_sel    = grp;
    item.function_set = fset;
    item.start_slot   = start;
    return item;
  endfunction

  function automatic rpot_in_t list_item(input logic [31:0] mask);
    rpot_in_t item;
    item           = random_fields();
    item.op        = OP_LIST;
    item.pass_mask = mask;
    return item;
  endfunction

  // Keys drawn often from a tiny set so equal keys (stable order) show up a lot.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return 32'h1 << $urandom_range(0, 31);
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. Valid stays up
  // across back-to-back beats; it is only dropped at the start of a gap.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input rpot_in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    apply_table_item(item);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: phases of no stall, light stall, heavy stall and a
  // fixed periodic rhythm from the cycle counter, each phase of random length.
  // ---------------------------------------------------------------------------
  int unsigned stall_phase_left = 0;
  int unsigned stall_style      = 0;

  always @(posedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_style      = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(10, 150);
    end
    stall_phase_left--;
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((cycle_count % 7) < 3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted beat against the oldest owed result.
  // ---------------------------------------------------------------------------
  rpot_out_t next_reply;

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, act_val);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (table_replies_q.size() == 0) begin
        $display("%0t: result beat with none owed: expected nothing, got %h",
                 $time, out_data_o);
        err_count++;
      end else begin
        next_reply = table_replies_q.pop_front();
        check_field("slot_id", next_reply.slot_id, out_data_o.slot_id);
        check_field("found", next_reply.found, out_data_o.found);
        check_field("slot_sort_kind", next_reply.slot_sort_kind, out_data_o.slot_sort_kind);
        check_field("slot_group", next_reply.slot_group, out_data_o.slot_group);
        check_field("slot_function_set", next_reply.slot_function_set,
                    out_data_o.slot_function_set);
        check_field("group_bits", next_reply.group_bits, out_data_o.group_bits);
        check_field("simple_sort_bits", next_reply.simple_sort_bits,
                    out_data_o.simple_sort_bits);
        check_field("last", next_reply.last, out_data_o.last);
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: any list, even all ones, finds nothing.
  task automatic test_empty_list();
    send_beat(list_item('1));
    send_beat(list_item('0));
  endtask

  // Field extremes, the top slot, and an add with nothing free at or above start.
  task automatic test_add_extremes();
    send_beat(add_item(32'h0000_0000, SORT_SIMPLE, 1'b0, 5'd0, 5'd31));
    send_beat(add_item(32'hFFFF_FFFF, 2'd3, 1'b1, 5'd31, 5'd31));  // slot 31 taken: fails
    send_beat(add_item(32'hFFFF_FFFF, 2'd3, 1'b1, 5'd31, 5'd0));   // fset past range kept
    send_beat(add_item(32'h8000_0000, 2'd1, 1'b1, 5'd19, 5'd16));
    send_beat(add_item(32'h7FFF_FFFF, 2'd2, 1'b0, 5'd20, 5'd30));
  endtask

  // Equal keys must list in arrival order.
  task automatic test_stable_ties();
    send_beat(add_item(32'h0000_0000, 2'd1, 1'b0, 5'd3, 5'd0));
    send_beat(add_item(32'h0000_0000, SORT_SIMPLE, 1'b1, 5'd4, 5'd0));
    send_beat(add_item(32'h0000_0000, 2'd2, 1'b1, 5'd5, 5'd0));
    send_beat(add_item(32'hFFFF_FFFF, SORT_SIMPLE, 1'b0, 5'd6, 5'd1));
    send_beat(add_item(32'h8000_0000, 2'd1, 1'b1, 5'd7, 5'd5));
    send_beat(list_item('1));
  endtask

  // No-match, single top bit, inactive-only mask, and both alternating-bit masks.
  task automatic test_list_masks();
    send_beat(list_item('0));
    send_beat(list_item(32'h8000_0000));
    send_beat(list_item(32'h0000_00C0));
    send_beat(list_item(32'h5555_5555));
    send_beat(list_item(32'hAAAA_AAAA));
  endtask

  // Mostly lists with random masks; adds fill the table over the run so the
  // walks get longer, and once full every add takes the no-room path.
  task automatic test_random_mix();
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 3)
        send_beat(add_item(pick_key(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))));
      else
        send_beat(list_item(pick_mask()));
    end
  endtask

  // Fill whatever is left, then overflow and walk the full 32-entry list.
  task automatic test_full_table();
    while (key_order.size() < SLOTS)
      send_beat(add_item(pick_key(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         5'($urandom_range(0, 31)), 5'd0));
    send_beat(add_item(32'h0000_0000, SORT_SIMPLE, 1'b0, 5'd0, 5'd0));
    send_beat(add_item(32'hFFFF_FFFF, 2'd1, 1'b1, 5'd19, 5'd31));
    send_beat(list_item('1));
    send_beat(list_item($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_add_extremes();
    test_stable_ties();
    test_list_masks();
    test_random_mix();
    test_full_table();
    in_valid_i <= 1'b0;
    while (table_replies_q.size() != 0) @(posedge clk_i);
    // catch any stray beats after the last owed one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
